### src/cgdm_pkg.sv
// Shared codes, field widths and control types of the CSR graph delta merge block.
`timescale 1ns / 1ps
`default_nettype none
package cgdm_pkg;

    localparam int NODES_DEF      = 1024;
    localparam int MAX_DEGREE_DEF = 32;

    localparam int KIND_W   = 3;
    localparam int OFFV_W   = 16;
    localparam int NODE_W   = 10;
    localparam int DOP_W    = 2;
    localparam int WGT_W    = 64;
    localparam int WK_W     = 2;
    localparam int VAL_W    = 16;
    localparam int ST_W     = 2;
    localparam int NCN_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 88;

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_BEGIN  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OFFSET = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TARGET = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELTA  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

    localparam logic [DOP_W-1:0] DOP_INSERT = 2'd1;
    localparam logic [DOP_W-1:0] DOP_DELETE = 2'd2;

    localparam logic [WK_W-1:0] WK_ACK    = 2'd0;
    localparam logic [WK_W-1:0] WK_OFFSET = 2'd1;
    localparam logic [WK_W-1:0] WK_TARGET = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd1;
    localparam logic [ST_W-1:0] ST_IGN  = 2'd2;
    localparam logic [ST_W-1:0] ST_PAST = 2'd3;

    localparam logic [1:0] PH_OFFS = 2'd0;
    localparam logic [1:0] PH_TGTS = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED   = 2'd1;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_CLR_INIT, OP_CLR_STEP, OP_OFF_WRITE,
        OP_RD_NEXT, OP_RD_CUR, OP_LN_INC, OP_ST_IGN, OP_IGN_ADV,
        OP_WN_LN_ADV, OP_WN_SRC, OP_ST_OVF, OP_APPEND, OP_SCAN_INIT,
        OP_SCAN_RD, OP_J_INC, OP_LAST_RD, OP_MOVE, OP_RN_CLAMP,
        OP_DEG_RD_RN, OP_OFF_ADV, OP_PH1_START, OP_ST_PAST, OP_SET_LAST,
        OP_RN_NEXT, OP_SLOT_RD_RS, OP_TGT_WORD, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DOP_W-1:0]  dop;
        logic [1:0]        phase;
        logic              off_full;
        logic              ln_lt_oc;
        logic              le_ge_off;
        logic              out_range;
        logic              deg_full;
        logic              j_lt_d;
        logic              hit;
        logic              rn_lt_n;
        logic              rs_ge_deg;
        logic              clr_done;
        logic              out_free;
    } t_sts;

endpackage
`default_nettype wire

### src/csr_graph_delta_merge.sv
// Top level of the CSR graph delta merge block: stream ports, config port, controller and datapath.
// Work per item: a delete scans the source node's slots, an old target steps past the nodes
//   before its own, and a target read skips empty nodes; memories are read through registers.
// Flow: one item at a time, the next taken while a result waits; begin runs a degree sweep.
// Reset: synchronous, active low; a degree sweep runs before the first item.
`timescale 1ns / 1ps
`default_nettype none
module csr_graph_delta_merge #(
    parameter int NODES      = cgdm_pkg::NODES_DEF,
    parameter int MAX_DEGREE = cgdm_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // offset_value[15:0], src_node[25:16], dst_node[35:26], delta_op[37:36],
    // weight_bits[101:38], zero pad
    input  wire logic [cgdm_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // kind[2:0]
    input  wire logic [cgdm_pkg::KIND_W-1:0]       i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // value[15:0], weight_out[79:16], status[81:80], zero pad
    output logic [cgdm_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    // word_kind[1:0]
    output logic [cgdm_pkg::WK_W-1:0]              o_m_tuser,
    output logic                                   o_m_tlast,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [cgdm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [cgdm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import cgdm_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic              in_accept;
    logic [VAL_W-1:0]  out_value;
    logic [WGT_W-1:0]  out_weight;
    logic [ST_W-1:0]   out_status;

    assign in_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;   // registers are plain flops, always writable

    cgdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_s_tready)
    );

    cgdm_dp #(
        .NODES      (NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_s_tuser),
        .i_offv      (i_s_tdata[15:0]),
        .i_src       (i_s_tdata[25:16]),
        .i_dst       (i_s_tdata[35:26]),
        .i_dop       (i_s_tdata[37:36]),
        .i_wgt       (i_s_tdata[101:38]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_take  (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_word_kind (o_m_tuser),
        .o_value     (out_value),
        .o_weight    (out_weight),
        .o_last      (o_m_tlast),
        .o_status    (out_status)
    );

    // result item packing
    assign o_m_tdata = {6'd0, out_status, out_weight, out_value};

endmodule
`default_nettype wire

### src/cgdm_dp.sv
// Datapath: item registers, offset/degree/slot memories, progress counters, output register.
`timescale 1ns / 1ps
`default_nettype none
module cgdm_dp #(
    parameter int NODES      = 1024,
    parameter int MAX_DEGREE = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire cgdm_pkg::t_cmd                 i_cmd,
    output cgdm_pkg::t_sts                      o_sts,
    input  wire logic [cgdm_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [cgdm_pkg::OFFV_W-1:0]    i_offv,
    input  wire logic [cgdm_pkg::NODE_W-1:0]    i_src,
    input  wire logic [cgdm_pkg::NODE_W-1:0]    i_dst,
    input  wire logic [cgdm_pkg::DOP_W-1:0]     i_dop,
    input  wire logic [cgdm_pkg::WGT_W-1:0]     i_wgt,
    input  wire logic                           i_cfg_we,
    input  wire logic [cgdm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cgdm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_out_take,
    output logic                                o_out_valid,
    output logic [cgdm_pkg::WK_W-1:0]           o_word_kind,
    output logic [cgdm_pkg::VAL_W-1:0]          o_value,
    output logic [cgdm_pkg::WGT_W-1:0]          o_weight,
    output logic                                o_last,
    output logic [cgdm_pkg::ST_W-1:0]           o_status
);
    import cgdm_pkg::*;

    localparam int AW    = $clog2(NODES);
    localparam int NW    = $clog2(NODES + 1);
    localparam int OLW   = $clog2(NODES + 2);
    localparam int CW    = (OLW > NCN_W) ? OLW : NCN_W;
    localparam int DW    = $clog2(MAX_DEGREE + 1);
    localparam int SLOTS = NODES * MAX_DEGREE;
    localparam int SAW   = $clog2(SLOTS);
    localparam int SLW   = NODE_W + WGT_W;

    // captured item
    logic [KIND_W-1:0] r_kind;
    logic [OFFV_W-1:0] r_offv;
    logic [NODE_W-1:0] r_src, r_dst;
    logic [DOP_W-1:0]  r_dop;
    logic [WGT_W-1:0]  r_wgt;

    logic [NCN_W-1:0]  r_ncn;
    logic              r_wtd;

    logic [OLW-1:0]    r_ol;
    logic [NW-1:0]     r_ln;
    logic [15:0]       r_le;
    logic [1:0]        r_ph;
    logic [NW-1:0]     r_rn;
    logic [DW-1:0]     r_rs;
    logic [15:0]       r_run;
    logic [AW-1:0]     r_clr;

    logic [AW-1:0]     r_wn;
    logic [DW-1:0]     r_d, r_j;

    // result being built
    logic [WK_W-1:0]   r_rwk;
    logic [VAL_W-1:0]  r_rval;
    logic [WGT_W-1:0]  r_rwt;
    logic              r_rlast;
    logic [ST_W-1:0]   r_rst;

    logic              r_ov;
    logic [WK_W-1:0]   r_owk;
    logic [VAL_W-1:0]  r_oval;
    logic [WGT_W-1:0]  r_owt;
    logic              r_olast;
    logic [ST_W-1:0]   r_ost;

    logic [15:0]       r_mem_off  [NODES+1];
    logic [DW-1:0]     r_mem_deg  [NODES];
    logic [SLW-1:0]    r_mem_slot [SLOTS];
    logic [15:0]       r_off_rd;
    logic [DW-1:0]     r_deg_rd;
    logic [SLW-1:0]    r_slot_rd;

    logic [CW-1:0]     oc, n_raw, eff;
    logic [NW-1:0]     off_ra;
    logic [AW-1:0]     deg_ra, deg_wa;
    logic [DW-1:0]     deg_wd;
    logic              deg_we, off_we, slot_we;
    logic [SAW-1:0]    slot_ra, slot_wa;
    logic [SLW-1:0]    slot_wd;

    function automatic logic [SAW-1:0] slot_addr(input logic [AW-1:0] node,
                                                 input logic [DW-1:0] slot);
        return SAW'(SAW'(node) * MAX_DEGREE + SAW'(slot));
    endfunction

    // effective node count: max(requested, old), capped
    always_comb begin
        oc    = (r_ol == '0) ? '0 : CW'(r_ol - OLW'(1));
        n_raw = (CW'(r_ncn) > oc) ? CW'(r_ncn) : oc;
        eff   = (n_raw > CW'(NODES)) ? CW'(NODES) : n_raw;
    end

    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.dop       = r_dop;
        o_sts.phase     = r_ph;
        o_sts.off_full  = r_ol >= OLW'(NODES + 1);
        o_sts.ln_lt_oc  = CW'(r_ln) < oc;
        o_sts.le_ge_off = r_le >= r_off_rd;
        o_sts.out_range = (CW'(r_src) >= eff) || (CW'(r_dst) >= eff);
        o_sts.deg_full  = r_deg_rd >= DW'(MAX_DEGREE);
        o_sts.j_lt_d    = r_j < r_d;
        o_sts.hit       = r_slot_rd[NODE_W-1:0] == r_dst;
        o_sts.rn_lt_n   = CW'(r_rn) < eff;
        o_sts.rs_ge_deg = r_rs >= r_deg_rd;
        o_sts.clr_done  = r_clr == AW'(NODES - 1);
        o_sts.out_free  = !r_ov || i_out_take;
    end

    // memory address and write selection
    always_comb begin
        off_ra  = r_ln;
        deg_ra  = r_rn[AW-1:0];
        slot_ra = slot_addr(r_rn[AW-1:0], r_rs);
        off_we  = (i_cmd.op == OP_OFF_WRITE) && !o_sts.off_full;
        deg_we  = 1'b0;
        deg_wa  = r_wn;
        deg_wd  = r_d;
        slot_we = 1'b0;
        slot_wa = slot_addr(r_wn, r_j);
        slot_wd = r_slot_rd;
        unique case (i_cmd.op)
            OP_RD_NEXT:  off_ra = r_ln + NW'(1);
            OP_WN_LN_ADV: deg_ra = r_ln[AW-1:0];
            OP_WN_SRC:   deg_ra = AW'(r_src);
            OP_SCAN_RD:  slot_ra = slot_addr(r_wn, r_j);
            OP_LAST_RD:  slot_ra = slot_addr(r_wn, r_d - DW'(1));
            OP_CLR_STEP: begin
                deg_we = 1'b1;
                deg_wa = r_clr;
                deg_wd = '0;
            end
            OP_APPEND: begin
                deg_we  = 1'b1;
                deg_wd  = r_deg_rd + DW'(1);
                slot_we = 1'b1;
                slot_wa = slot_addr(r_wn, r_deg_rd);
                slot_wd = {r_wgt, r_dst};
            end
            OP_MOVE: begin
                deg_we  = 1'b1;
                slot_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (off_we) begin
            r_mem_off[r_ol[NW-1:0]] <= r_offv;
        end
        if (deg_we) begin
            r_mem_deg[deg_wa] <= deg_wd;
        end
        if (slot_we) begin
            r_mem_slot[slot_wa] <= slot_wd;
        end
        r_off_rd  <= r_mem_off[off_ra];
        r_deg_rd  <= r_mem_deg[deg_ra];
        r_slot_rd <= r_mem_slot[slot_ra];
    end

    // control and progress state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncn <= '0;
            r_wtd <= 1'b0;
            r_ol  <= '0;
            r_ln  <= '0;
            r_le  <= '0;
            r_ph  <= PH_OFFS;
            r_rn  <= '0;
            r_rs  <= '0;
            r_run <= '0;
            r_clr <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_NODE_COUNT) begin
                r_ncn <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == REG_WEIGHTED) begin
                r_wtd <= i_cfg_data[0];
            end
            if (i_out_take) begin
                r_ov <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_CLR_INIT: begin
                    r_ol  <= '0;
                    r_ln  <= '0;
                    r_le  <= '0;
                    r_ph  <= PH_OFFS;
                    r_rn  <= '0;
                    r_rs  <= '0;
                    r_run <= '0;
                    r_clr <= '0;
                end
                OP_CLR_STEP:  r_clr <= r_clr + AW'(1);
                OP_OFF_WRITE: if (!o_sts.off_full) r_ol <= r_ol + OLW'(1);
                OP_LN_INC:    r_ln <= r_ln + NW'(1);
                OP_IGN_ADV, OP_WN_LN_ADV: begin
                    if (r_le != 16'hFFFF) r_le <= r_le + 16'd1;
                end
                OP_RN_CLAMP:  if (CW'(r_rn) > eff) r_rn <= NW'(eff);
                OP_OFF_ADV: begin
                    r_run <= r_run + 16'(r_deg_rd);
                    r_rn  <= r_rn + NW'(1);
                end
                OP_PH1_START: begin
                    r_ph <= PH_TGTS;
                    r_rn <= '0;
                    r_rs <= '0;
                end
                OP_ST_PAST, OP_SET_LAST: r_ph <= PH_DONE;
                OP_RN_NEXT: begin
                    r_rn <= r_rn + NW'(1);
                    r_rs <= '0;
                end
                OP_TGT_WORD: r_rs <= r_rs + DW'(1);
                OP_EMIT:     r_ov <= 1'b1;
                default: ;
            endcase
        end
    end

    // item, working and result payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_kind  <= i_kind;
                r_offv  <= i_offv;
                r_src   <= i_src;
                r_dst   <= i_dst;
                r_dop   <= i_dop;
                r_wgt   <= i_wgt;
                r_rwk   <= WK_ACK;
                r_rval  <= '0;
                r_rwt   <= '0;
                r_rlast <= 1'b0;
                r_rst   <= ST_OK;
            end
            OP_OFF_WRITE: if (o_sts.off_full) r_rst <= ST_IGN;
            OP_ST_IGN, OP_IGN_ADV: r_rst <= ST_IGN;
            OP_ST_OVF:    r_rst <= ST_OVF;
            OP_ST_PAST:   r_rst <= ST_PAST;
            OP_SET_LAST:  r_rlast <= 1'b1;
            OP_WN_LN_ADV: r_wn <= r_ln[AW-1:0];
            OP_WN_SRC:    r_wn <= AW'(r_src);
            OP_SCAN_INIT: begin
                r_d <= r_deg_rd;
                r_j <= '0;
            end
            OP_J_INC:     r_j <= r_j + DW'(1);
            OP_LAST_RD:   r_d <= r_d - DW'(1);
            OP_OFF_ADV, OP_PH1_START: begin
                r_rwk  <= WK_OFFSET;
                r_rval <= r_run;
            end
            OP_TGT_WORD: begin
                r_rwk  <= WK_TARGET;
                r_rval <= VAL_W'(r_slot_rd[NODE_W-1:0]);
                r_rwt  <= r_wtd ? r_slot_rd[SLW-1:NODE_W] : '0;
            end
            OP_EMIT: begin
                r_owk   <= r_rwk;
                r_oval  <= r_rval;
                r_owt   <= r_rwt;
                r_olast <= r_rlast;
                r_ost   <= r_rst;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_word_kind = r_owk;
    assign o_value     = r_oval;
    assign o_weight    = r_owt;
    assign o_last      = r_olast;
    assign o_status    = r_ost;

endmodule
`default_nettype wire

### src/cgdm_ctrl.sv
// Controller: sequences each item kind over the datapath by command codes.
`timescale 1ns / 1ps
`default_nettype none
module cgdm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire cgdm_pkg::t_sts i_sts,
    output cgdm_pkg::t_cmd      o_cmd,
    output logic                o_in_ready
);
    import cgdm_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP, S_K2_CHK, S_K2_NX, S_K2_CC, S_AP_CHK,
        S_D_CHK, S_DL_INIT, S_DL_CHK, S_DL_CMP, S_DL_MOVE, S_R_START,
        S_R0_CHK, S_R0_ADD, S_SK_CHK, S_SK_EVAL, S_R1_WORD, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_boot, n_boot;
    logic   r_first, n_first;   // seek for the first target of a read

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_boot  <= 1'b1;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_boot  <= n_boot;
            r_first <= n_first;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_boot   = r_boot;
        n_first  = r_first;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR_STEP;
                if (i_sts.clr_done) begin
                    n_state = r_boot ? S_IDLE : S_EMIT;
                    n_boot  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                priority case (i_sts.kind)
                    KIND_BEGIN: begin
                        o_cmd.op = OP_CLR_INIT;
                        n_state  = S_CLR;
                    end
                    KIND_OFFSET: begin
                        o_cmd.op = OP_OFF_WRITE;
                        n_state  = S_EMIT;
                    end
                    KIND_TARGET: n_state = S_K2_CHK;
                    KIND_DELTA:  n_state = S_D_CHK;
                    KIND_READ:   n_state = S_R_START;
                    default: begin
                        o_cmd.op = OP_ST_IGN;
                        n_state  = S_EMIT;
                    end
                endcase
            end
            S_K2_CHK: begin
                if (i_sts.ln_lt_oc) begin
                    o_cmd.op = OP_RD_NEXT;
                    n_state  = S_K2_NX;
                end else begin
                    o_cmd.op = OP_IGN_ADV;
                    n_state  = S_EMIT;
                end
            end
            S_K2_NX: begin
                if (i_sts.le_ge_off) begin
                    o_cmd.op = OP_LN_INC;
                    n_state  = S_K2_CHK;
                end else begin
                    o_cmd.op = OP_RD_CUR;
                    n_state  = S_K2_CC;
                end
            end
            S_K2_CC: begin
                if (!i_sts.le_ge_off) begin
                    o_cmd.op = OP_IGN_ADV;
                    n_state  = S_EMIT;
                end else begin
                    o_cmd.op = OP_WN_LN_ADV;
                    n_state  = S_AP_CHK;
                end
            end
            S_AP_CHK: begin
                o_cmd.op = i_sts.deg_full ? OP_ST_OVF : OP_APPEND;
                n_state  = S_EMIT;
            end
            S_D_CHK: begin
                if (i_sts.out_range) begin
                    o_cmd.op = OP_ST_IGN;
                    n_state  = S_EMIT;
                end else if (i_sts.dop == DOP_DELETE) begin
                    o_cmd.op = OP_WN_SRC;
                    n_state  = S_DL_INIT;
                end else if (i_sts.dop == DOP_INSERT) begin
                    o_cmd.op = OP_WN_SRC;
                    n_state  = S_AP_CHK;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DL_INIT: begin
                o_cmd.op = OP_SCAN_INIT;
                n_state  = S_DL_CHK;
            end
            S_DL_CHK: begin
                if (i_sts.j_lt_d) begin
                    o_cmd.op = OP_SCAN_RD;
                    n_state  = S_DL_CMP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DL_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.op = OP_LAST_RD;
                    n_state  = S_DL_MOVE;
                end else begin
                    o_cmd.op = OP_J_INC;
                    n_state  = S_DL_CHK;
                end
            end
            S_DL_MOVE: begin
                o_cmd.op = OP_MOVE;
                n_state  = S_EMIT;
            end
            S_R_START: begin
                priority case (i_sts.phase)
                    PH_OFFS: begin
                        o_cmd.op = OP_RN_CLAMP;
                        n_state  = S_R0_CHK;
                    end
                    PH_TGTS: begin
                        n_first = 1'b1;
                        n_state = S_SK_CHK;
                    end
                    default: begin
                        o_cmd.op = OP_ST_PAST;
                        n_state  = S_EMIT;
                    end
                endcase
            end
            S_R0_CHK: begin
                if (i_sts.rn_lt_n) begin
                    o_cmd.op = OP_DEG_RD_RN;
                    n_state  = S_R0_ADD;
                end else begin
                    o_cmd.op = OP_PH1_START;
                    n_first  = 1'b0;
                    n_state  = S_SK_CHK;
                end
            end
            S_R0_ADD: begin
                o_cmd.op = OP_OFF_ADV;
                n_state  = S_EMIT;
            end
            S_SK_CHK: begin
                if (i_sts.rn_lt_n) begin
                    o_cmd.op = OP_DEG_RD_RN;
                    n_state  = S_SK_EVAL;
                end else begin
                    o_cmd.op = r_first ? OP_ST_PAST : OP_SET_LAST;
                    n_state  = S_EMIT;
                end
            end
            S_SK_EVAL: begin
                if (i_sts.rs_ge_deg) begin
                    o_cmd.op = OP_RN_NEXT;
                    n_state  = S_SK_CHK;
                end else if (r_first) begin
                    o_cmd.op = OP_SLOT_RD_RS;
                    n_state  = S_R1_WORD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_R1_WORD: begin
                o_cmd.op = OP_TGT_WORD;
                n_first  = 1'b0;
                n_state  = S_SK_CHK;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### src/cgdm_chk.sv
// Port-level assertion checker for the CSR graph delta merge block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module cgdm_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_s_tvalid,
    input wire logic                              o_s_tready,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [cgdm_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input wire logic [cgdm_pkg::WK_W-1:0]         o_m_tuser,
    input wire logic                              o_m_tlast
);
    import cgdm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result item changed while stalled");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |->
            (o_m_tuser == WK_OFFSET || o_m_tuser == WK_TARGET) && o_m_tdata[81:80] == ST_OK)
        else $error("last flag on a non-data word");

    a_weight_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != WK_TARGET |-> o_m_tdata[79:16] == '0)
        else $error("weight on a non-target word");

    a_status_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[81:80] != ST_OK |->
            o_m_tuser == WK_ACK && o_m_tdata[15:0] == '0)
        else $error("error status on a data word");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item taken while one is in work");

endmodule

bind csr_graph_delta_merge cgdm_chk u_cgdm_chk (.*);
`default_nettype wire
